/* rtl/bpqp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpqp_pkg
// Shared types, constants and pattern table for the beep pattern queue player.
// ----------------------------------------------------------------------------
package bpqp_pkg;

    // Depth of the pattern id queue (1 to 15, as the reported fill is COUNT_W bits).
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths.
    localparam int PAT_W   = 3;
    localparam int REM_W   = 9;
    localparam int COUNT_W = 4;

    // Pattern ids.
    localparam logic [PAT_W-1:0] ID_TAP     = 3'd1;
    localparam logic [PAT_W-1:0] ID_TARE_OK = 3'd2;
    localparam logic [PAT_W-1:0] ID_CAL_OK  = 3'd3;
    localparam logic [PAT_W-1:0] ID_ERROR   = 3'd4;
    localparam logic [PAT_W-1:0] ID_BUSY    = 3'd5;

    // Phase lengths in milliseconds.
    localparam logic [REM_W-1:0] LEN_TAP      = 9'd30;
    localparam logic [REM_W-1:0] LEN_TARE_OK  = 9'd120;
    localparam logic [REM_W-1:0] LEN_CAL_ON   = 9'd100;
    localparam logic [REM_W-1:0] LEN_CAL_OFF  = 9'd80;
    localparam logic [REM_W-1:0] LEN_ERROR    = 9'd400;
    localparam logic [REM_W-1:0] LEN_BUSY     = 9'd40;

    // Input item modes.
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_POST = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ON1  = 2'd1,
        PH_OFF1 = 2'd2,
        PH_ON2  = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t             ph;
        logic [REM_W-1:0]   len;
    } phase_step_t;

    typedef struct packed {
        logic               push;
        logic               pop;
        logic [PAT_W-1:0]   wdata;
    } fifo_ctrl_t;

    typedef struct packed {
        logic               empty;
        logic               full;
        logic [QCNT_W-1:0]  count_next;
        logic [PAT_W-1:0]   head_data;
    } fifo_stat_t;

    typedef struct packed {
        logic               buzzer_on;
        logic               dropped;
        logic [COUNT_W-1:0] queue_count;
        logic               playing;
    } result_t;

    // Length of one phase of a pattern; zero where the phase is absent.
    function automatic logic [REM_W-1:0] beep_len(input logic [PAT_W-1:0] pat,
                                                  input phase_t ph);
        logic [REM_W-1:0] len;
        len = '0;
        case (pat)
            ID_TAP:     len = (ph == PH_ON1) ? LEN_TAP : '0;
            ID_TARE_OK: len = (ph == PH_ON1) ? LEN_TARE_OK : '0;
            ID_CAL_OK:  len = (ph == PH_OFF1) ? LEN_CAL_OFF :
                              (ph == PH_IDLE) ? '0 : LEN_CAL_ON;
            ID_ERROR:   len = (ph == PH_ON1) ? LEN_ERROR : '0;
            ID_BUSY:    len = (ph == PH_ON1) ? LEN_BUSY : '0;
            default:    len = '0;
        endcase
        return len;
    endfunction

    // First phase after 'from' with a nonzero length, or idle.
    function automatic phase_step_t next_phase(input logic [PAT_W-1:0] pat,
                                               input phase_t from);
        phase_step_t      step;
        logic [REM_W-1:0] l1;
        logic [REM_W-1:0] l2;
        logic [REM_W-1:0] l3;
        l1 = beep_len(pat, PH_ON1);
        l2 = beep_len(pat, PH_OFF1);
        l3 = beep_len(pat, PH_ON2);
        step.ph  = PH_IDLE;
        step.len = '0;
        case (from)
            PH_IDLE:
            begin
                if (l1 != '0) begin
                    step.ph  = PH_ON1;
                    step.len = l1;
                end else if (l2 != '0) begin
                    step.ph  = PH_OFF1;
                    step.len = l2;
                end else if (l3 != '0) begin
                    step.ph  = PH_ON2;
                    step.len = l3;
                end
            end
            PH_ON1:
            begin
                if (l2 != '0) begin
                    step.ph  = PH_OFF1;
                    step.len = l2;
                end else if (l3 != '0) begin
                    step.ph  = PH_ON2;
                    step.len = l3;
                end
            end
            PH_OFF1:
            begin
                if (l3 != '0) begin
                    step.ph  = PH_ON2;
                    step.len = l3;
                end
            end
            default:
            begin
                step.ph  = PH_IDLE;
                step.len = '0;
            end
        endcase
        return step;
    endfunction

endpackage
`default_nettype wire

/* rtl/bpqp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpqp_in_if / bpqp_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface bpqp_in_if;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [bpqp_pkg::PAT_W-1:0] pattern;

    modport source (output valid, output mode, output pattern, input ready);
    modport sink   (input valid, input mode, input pattern, output ready);
endinterface

interface bpqp_out_if;
    logic                        valid;
    logic                        ready;
    logic                        buzzer_on;
    logic                        dropped;
    logic [bpqp_pkg::COUNT_W-1:0] queue_count;
    logic                        playing;

    modport source (output valid, output buzzer_on, output dropped,
                    output queue_count, output playing, input ready);
    modport sink   (input valid, input buzzer_on, input dropped,
                    input queue_count, input playing, output ready);
endinterface
`default_nettype wire

/* rtl/bpqp_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpqp_fifo
// Queue of pattern ids with a registered read of the head entry.
// ----------------------------------------------------------------------------
module bpqp_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bpqp_pkg::fifo_ctrl_t ctrl,
    output bpqp_pkg::fifo_stat_t      stat
);

    localparam logic [bpqp_pkg::QPTR_W-1:0] LAST_PTR =
        bpqp_pkg::QPTR_W'(bpqp_pkg::QUEUE_DEPTH - 1);
    localparam logic [bpqp_pkg::QCNT_W-1:0] FULL_COUNT =
        bpqp_pkg::QCNT_W'(bpqp_pkg::QUEUE_DEPTH);

    logic [bpqp_pkg::PAT_W-1:0]  mem [bpqp_pkg::QUEUE_DEPTH];
    logic [bpqp_pkg::QPTR_W-1:0] head_reg;
    logic [bpqp_pkg::QPTR_W-1:0] head_next;
    logic [bpqp_pkg::QPTR_W-1:0] tail_reg;
    logic [bpqp_pkg::QPTR_W-1:0] tail_next;
    logic [bpqp_pkg::QCNT_W-1:0] count_reg;
    logic [bpqp_pkg::QCNT_W-1:0] count_next;
    logic [bpqp_pkg::PAT_W-1:0]  head_data_reg;

    // Pointer and count updates; pointers wrap at the queue depth.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.pop) begin
            head_next  = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (ctrl.push) begin
            tail_next  = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Storage write at the tail.
    always_ff @(posedge clk)
    begin
        if (ctrl.push) begin
            mem[tail_reg] <= ctrl.wdata;
        end
    end

    // Registered read of the next head entry, with bypass of a same-cycle write.
    always_ff @(posedge clk)
    begin
        if (ctrl.push && (tail_reg == head_next)) begin
            head_data_reg <= ctrl.wdata;
        end else begin
            head_data_reg <= mem[head_next];
        end
    end

    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg == FULL_COUNT);
    assign stat.count_next = count_next;
    assign stat.head_data  = head_data_reg;

endmodule
`default_nettype wire

/* rtl/bpqp_player.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpqp_player
// Phase sequencer and millisecond countdown for the current pattern.
// ----------------------------------------------------------------------------
module bpqp_player (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       tick,
    input  wire logic                       fifo_empty,
    input  wire logic [bpqp_pkg::PAT_W-1:0] head_data,
    output logic                            pop,
    output bpqp_pkg::phase_t                phase_next
);

    bpqp_pkg::phase_t            phase_reg;
    logic [bpqp_pkg::REM_W-1:0]  remaining_reg;
    logic [bpqp_pkg::REM_W-1:0]  remaining_next;
    logic [bpqp_pkg::PAT_W-1:0]  pattern_reg;
    logic [bpqp_pkg::PAT_W-1:0]  pattern_next;
    logic [bpqp_pkg::REM_W-1:0]  remaining_dec;
    bpqp_pkg::phase_step_t       step;

    // Next state: an idle tick starts the head id; a tick counts down, moving to the next nonzero phase at zero.
    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        pattern_next   = pattern_reg;
        remaining_dec  = (remaining_reg == '0) ? '0 : remaining_reg - 1'b1;
        step.ph        = bpqp_pkg::PH_IDLE;
        step.len       = '0;
        if (tick) begin
            case (phase_reg)
                bpqp_pkg::PH_IDLE:
                begin
                    if (!fifo_empty) begin
                        pattern_next   = head_data;
                        step           = bpqp_pkg::next_phase(head_data, bpqp_pkg::PH_IDLE);
                        phase_next     = step.ph;
                        remaining_next = step.len;
                    end
                end
                default:
                begin
                    if (remaining_dec == '0) begin
                        step           = bpqp_pkg::next_phase(pattern_reg, phase_reg);
                        phase_next     = step.ph;
                        remaining_next = step.len;
                    end else begin
                        remaining_next = remaining_dec;
                    end
                end
            endcase
        end
    end

    // Outputs: an idle tick with a waiting id takes it from the queue.
    always_comb
    begin
        pop = tick && (phase_reg == bpqp_pkg::PH_IDLE) && !fifo_empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= bpqp_pkg::PH_IDLE;
            remaining_reg <= '0;
            pattern_reg   <= '0;
        end else begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            pattern_reg   <= pattern_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/bpqp_outbuf.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpqp_outbuf
// Result register with a skid stage in front of the output channel.
// ----------------------------------------------------------------------------
module bpqp_outbuf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire bpqp_pkg::result_t data,
    output logic                   can_accept,
    bpqp_out_if.source             out_ch
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    bpqp_pkg::result_t out_data_reg;
    bpqp_pkg::result_t skid_data_reg;
    logic              advance;

    // The output register moves when it is empty or its item is taken.
    assign advance    = !out_valid_reg || out_ch.ready;
    assign can_accept = !skid_valid_reg;

    // Control state of the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload of the two stages.
    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : data;
        end else if (push) begin
            skid_data_reg <= data;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.buzzer_on   = out_data_reg.buzzer_on;
    assign out_ch.dropped     = out_data_reg.dropped;
    assign out_ch.queue_count = out_data_reg.queue_count;
    assign out_ch.playing     = out_data_reg.playing;

endmodule
`default_nettype wire

/* rtl/beep_pattern_queue_player.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// beep_pattern_queue_player
// Plays buzzer beep patterns taken from a queue of pattern ids.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per handshake: mode 1 posts a pattern id, mode 0
//   is a one-millisecond tick. A post is queued unless the block is disabled
//   or the queue is full, in which case the result reports it as dropped.
//   An idle tick starts the oldest queued pattern.
//   out_ch returns one result item per input item: buzzer level, drop flag,
//   queue fill and playing flag, all as they stand after that item.
//   cfg_wr_en/cfg_wr_data write the enable bit; change it only while idle.
// Timing:
//   A result is registered into the output register, or into the skid stage
//   when the output is stalled. One item is taken every cycle while
//   in_ch.ready is high; the queue and phase counter update as it is taken.
// Reset:
//   The block comes up disabled, with an empty queue and the player idle.
// Stall:
//   A result and a skid stage hold two items; in_ch.ready drops only when
//   both are full, and results are never lost.
// ----------------------------------------------------------------------------
module beep_pattern_queue_player (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_wr_en,
    input  wire logic cfg_wr_data,
    bpqp_in_if.sink   in_ch,
    bpqp_out_if.source out_ch
);

    logic                 enabled_reg;
    logic                 accept;
    logic                 post;
    logic                 tick;
    logic                 can_accept;
    logic                 pop;
    bpqp_pkg::phase_t     phase_next;
    bpqp_pkg::fifo_ctrl_t fifo_ctrl;
    bpqp_pkg::fifo_stat_t fifo_stat;
    bpqp_pkg::result_t    result;

    // Enable register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            enabled_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            enabled_reg <= cfg_wr_data;
        end
    end

    // Item decode.
    assign in_ch.ready = can_accept;
    assign accept      = in_ch.valid && can_accept;
    assign post        = accept && (in_ch.mode == bpqp_pkg::MODE_POST);
    assign tick        = accept && (in_ch.mode == bpqp_pkg::MODE_TICK);

    // Queue control.
    assign fifo_ctrl.push  = post && enabled_reg && !fifo_stat.full;
    assign fifo_ctrl.pop   = pop;
    assign fifo_ctrl.wdata = in_ch.pattern;

    bpqp_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (fifo_ctrl),
        .stat  (fifo_stat)
    );

    bpqp_player u_player (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .fifo_empty (fifo_stat.empty),
        .head_data  (fifo_stat.head_data),
        .pop        (pop),
        .phase_next (phase_next)
    );

    // Result of this item from the state it leaves behind.
    always_comb
    begin
        result.buzzer_on   = (phase_next == bpqp_pkg::PH_ON1) ||
                             (phase_next == bpqp_pkg::PH_ON2);
        result.dropped     = post && !fifo_ctrl.push;
        result.queue_count = bpqp_pkg::COUNT_W'(fifo_stat.count_next);
        result.playing     = (phase_next != bpqp_pkg::PH_IDLE);
    end

    bpqp_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .data       (result),
        .can_accept (can_accept),
        .out_ch     (out_ch)
    );

endmodule
`default_nettype wire

/* rtl/bpqp_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpqp_checker
// Port-level checks for the beep pattern queue player.
// ----------------------------------------------------------------------------
module bpqp_checker (
    input wire logic  clk,
    input wire logic  rst_n,
    bpqp_in_if.sink   in_ch,
    bpqp_out_if.source out_ch
);

    // The buzzer only sounds while a pattern plays.
    a_buzzer_playing: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.buzzer_on |-> out_ch.playing)
        else $error("buzzer on while not playing");

    // The reported fill never exceeds the queue depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (int'(out_ch.queue_count) <= bpqp_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    // Backpressure on the input only comes from a waiting result.
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> out_ch.valid)
        else $error("input stalled with no result waiting");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid &&
            $stable(out_ch.buzzer_on) && $stable(out_ch.dropped) &&
            $stable(out_ch.queue_count) && $stable(out_ch.playing))
        else $error("stalled result changed");

endmodule

bind beep_pattern_queue_player bpqp_checker u_bpqp_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
);
`default_nettype wire

/* test/beep_pattern_queue_player_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// beep_pattern_queue_player_checker
// Watches the request and result channels of the beep pattern queue player.
// It keeps its own copy of the queue and the player and predicts the result
// of every accepted item. Each accepted result is compared field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
module beep_pattern_queue_player_checker
    import bpqp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_wr_en,
    input  wire logic cfg_wr_data,
    bpqp_in_if        in_ch,
    bpqp_out_if       out_ch,
    output int        errors,
    output int        pending,
    output int        drop_count,
    output int        start_count
);

    // Predicted copy of the enable bit, the id queue and the player.
    logic             en_reg;
    logic [PAT_W-1:0] id_store [QUEUE_DEPTH];
    int               rd_ptr;
    int               held;
    logic [PAT_W-1:0] now_playing;
    phase_t           cur_phase;
    logic [REM_W-1:0] ms_left;

    // Predicted results that have not come out yet, oldest first.
    result_t          predicted_results [$];

    // Length in milliseconds of one phase of a pattern, zero when absent.
    function automatic logic [REM_W-1:0] phase_ms(input logic [PAT_W-1:0] pat,
                                                  input phase_t ph);
        logic [REM_W-1:0] on1;
        logic [REM_W-1:0] off1;
        logic [REM_W-1:0] on2;
        on1  = '0;
        off1 = '0;
        on2  = '0;
        case (pat)
            ID_TAP:     on1 = LEN_TAP;
            ID_TARE_OK: on1 = LEN_TARE_OK;
            ID_CAL_OK:
            begin
                on1  = LEN_CAL_ON;
                off1 = LEN_CAL_OFF;
                on2  = LEN_CAL_ON;
            end
            ID_ERROR:   on1 = LEN_ERROR;
            ID_BUSY:    on1 = LEN_BUSY;
            default:    on1 = '0;
        endcase
        case (ph)
            PH_ON1:  return on1;
            PH_OFF1: return off1;
            PH_ON2:  return on2;
            default: return '0;
        endcase
    endfunction

    // Move the player to the next phase with a nonzero length, or to idle.
    task automatic advance_phase(input phase_t from);
        bit found;
        found = 1'b0;
        for (int q = int'(from) + 1; q <= int'(PH_ON2); q++) begin
            if (!found && phase_ms(now_playing, phase_t'(q)) != '0) begin
                cur_phase = phase_t'(q);
                ms_left   = phase_ms(now_playing, phase_t'(q));
                found     = 1'b1;
            end
        end
        if (!found) begin
            cur_phase = PH_IDLE;
            ms_left   = '0;
        end
    endtask

    // Apply one request item to the predicted state and form its result.
    task automatic play_item(input logic mode, input logic [PAT_W-1:0] pat,
                             output result_t res);
        res = '0;
        if (mode == MODE_POST) begin
            if (!en_reg || held >= QUEUE_DEPTH) begin
                res.dropped = 1'b1;
                drop_count++;
            end else begin
                id_store[(rd_ptr + held) % QUEUE_DEPTH] = pat;
                held++;
            end
        end else if (cur_phase != PH_IDLE) begin
            // A tick counts down the running phase.
            if (ms_left != '0) begin
                ms_left = ms_left - 1'b1;
            end
            if (ms_left == '0) begin
                advance_phase(cur_phase);
            end
        end else if (held != 0) begin
            // An idle tick pops the oldest id; ids without a pattern vanish.
            now_playing = id_store[rd_ptr];
            rd_ptr      = (rd_ptr + 1) % QUEUE_DEPTH;
            held--;
            advance_phase(PH_IDLE);
            if (cur_phase != PH_IDLE) begin
                start_count++;
            end
        end
        res.buzzer_on   = (cur_phase == PH_ON1) || (cur_phase == PH_ON2);
        res.queue_count = held[COUNT_W-1:0];
        res.playing     = (cur_phase != PH_IDLE);
    endtask

    // Predict on every accepted item and compare every accepted result.
    always @(posedge clk or negedge rst_n)
    begin : track_items
        result_t want;
        if (!rst_n) begin
            en_reg      = 1'b0;
            rd_ptr      = 0;
            held        = 0;
            now_playing = '0;
            cur_phase   = PH_IDLE;
            ms_left     = '0;
            errors      = 0;
            pending     = 0;
            drop_count  = 0;
            start_count = 0;
            predicted_results.delete();
        end else begin
            if (cfg_wr_en) begin
                en_reg = cfg_wr_data;
            end
            if (in_ch.valid && in_ch.ready) begin
                play_item(in_ch.mode, in_ch.pattern, want);
                predicted_results.push_back(want);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (predicted_results.size() == 0) begin
                    $error("result item with no request item outstanding");
                    errors++;
                end else begin
                    want = predicted_results.pop_front();
                    if (out_ch.buzzer_on !== want.buzzer_on) begin
                        $error("buzzer_on: expected %0d, actual %0d",
                               want.buzzer_on, out_ch.buzzer_on);
                        errors++;
                    end
                    if (out_ch.dropped !== want.dropped) begin
                        $error("dropped: expected %0d, actual %0d",
                               want.dropped, out_ch.dropped);
                        errors++;
                    end
                    if (out_ch.queue_count !== want.queue_count) begin
                        $error("queue_count: expected %0d, actual %0d",
                               want.queue_count, out_ch.queue_count);
                        errors++;
                    end
                    if (out_ch.playing !== want.playing) begin
                        $error("playing: expected %0d, actual %0d",
                               want.playing, out_ch.playing);
                        errors++;
                    end
                end
            end
            pending = predicted_results.size();
        end
    end

endmodule
`default_nettype wire

/* test/beep_pattern_queue_player_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// beep_pattern_queue_player_test
// Drives posts and millisecond ticks into the beep pattern queue player with
// random gaps and output stalls, and gives the verdict. A short directed
// sequence covers dropping while disabled, silent ids, a full queue and a
// tick on an empty queue; random phases then vary the enable bit, the post
// rate and the idling, including one long output hold-off.
// ----------------------------------------------------------------------------
module beep_pattern_queue_player_test;
    import bpqp_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PHASES = 11;
    localparam int PHASE_ITEMS   = 148;
    localparam int DRAIN_CYCLES  = 4;

    // Ids that have no pattern.
    localparam logic [PAT_W-1:0] ID_UNUSED_0 = 3'd0;
    localparam logic [PAT_W-1:0] ID_UNUSED_6 = 3'd6;
    localparam logic [PAT_W-1:0] ID_UNUSED_7 = 3'd7;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    bpqp_in_if  in_ch ();
    bpqp_out_if out_ch ();

    int errors;
    int pending;
    int drop_count;
    int start_count;
    int cycle_count = 0;
    int sent_posts  = 0;
    int sent_ticks  = 0;
    int enable_writes = 0;
    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    bit hold_request = 1'b0;

    beep_pattern_queue_player dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    beep_pattern_queue_player_checker player_model (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .errors      (errors),
        .pending     (pending),
        .drop_count  (drop_count),
        .start_count (start_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up when the run takes far longer than any correct run would.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Number of idle cycles before the next item on one side.
    function automatic int pick_gap(input bit idle_en);
        if (!idle_en) begin
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    // Pattern id for a post, weighted toward the short patterns.
    function automatic logic [PAT_W-1:0] pick_pattern();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return ID_UNUSED_0;
        if (r < 20) return ID_UNUSED_6;
        if (r < 30) return ID_UNUSED_7;
        if (r < 50) return ID_TAP;
        if (r < 70) return ID_BUSY;
        if (r < 85) return ID_TARE_OK;
        if (r < 95) return ID_CAL_OK;
        return ID_ERROR;
    endfunction

    // Offer one item after a random gap and wait until it is taken.
    task automatic send_item(input logic mode, input logic [PAT_W-1:0] pat);
        int gap;
        gap = pick_gap(src_idle_en);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= mode;
        in_ch.pattern <= pat;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
        if (mode == MODE_POST) sent_posts++;
        else sent_ticks++;
    endtask

    // Stop offering and wait until every predicted result has come out.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_enable(input bit en);
        cfg_wr_data <= en;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        enable_writes++;
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (hold_request) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            stall = pick_gap(sink_idle_en);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
            @(negedge clk);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int post_pct;
        in_ch.valid   = 1'b0;
        in_ch.mode    = MODE_TICK;
        in_ch.pattern = '0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        rst_n         = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Disabled after reset: a post is dropped; a tick on an empty queue.
        send_item(MODE_POST, ID_TAP);
        send_item(MODE_TICK, ID_UNUSED_7);
        drain();
        set_enable(1'b1);

        // Silent ids are popped and skipped, then a tap starts.
        send_item(MODE_POST, ID_UNUSED_0);
        send_item(MODE_POST, ID_UNUSED_7);
        send_item(MODE_POST, ID_UNUSED_6);
        send_item(MODE_POST, ID_TAP);
        repeat (4) send_item(MODE_TICK, 3'($urandom_range(0, 7)));

        // Fill the queue with every pattern, then overflow it once.
        send_item(MODE_POST, ID_TARE_OK);
        send_item(MODE_POST, ID_CAL_OK);
        send_item(MODE_POST, ID_ERROR);
        send_item(MODE_POST, ID_BUSY);
        send_item(MODE_POST, ID_TAP);
        send_item(MODE_POST, ID_TARE_OK);
        send_item(MODE_POST, ID_CAL_OK);
        send_item(MODE_POST, ID_ERROR);
        send_item(MODE_POST, ID_BUSY);
        send_item(MODE_TICK, ID_UNUSED_0);

        // Disabling drops posts but leaves the queue in place.
        drain();
        set_enable(1'b0);
        send_item(MODE_POST, ID_CAL_OK);
        send_item(MODE_TICK, ID_UNUSED_7);

        // Random phases with varying enable, post rate and idling.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            set_enable((p % 4) != 2);
            case (p % 3)
                0:       post_pct = 35;
                1:       post_pct = 4;
                default: post_pct = 12;
            endcase
            src_idle_en  = ((p % 4) != 1);
            sink_idle_en = ((p % 4) != 1);
            if (p == 0) begin
                hold_request = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 99) < post_pct) begin
                    send_item(MODE_POST, pick_pattern());
                end else begin
                    send_item(MODE_TICK, 3'($urandom_range(0, 7)));
                end
            end
        end
        drain();

        $display("Run covered %0d posts (%0d dropped) and %0d ticks.",
                 sent_posts, drop_count, sent_ticks);
        $display("Patterns started: %0d; enable bit written %0d times.",
                 start_count, enable_writes);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire
